>>> src/tensor_cubic_spline_window_macros.svh
// Assertion helpers used by the checker file tcsw_checker.sv.
`ifndef TENSOR_CUBIC_SPLINE_WINDOW_MACROS_SVH
`define TENSOR_CUBIC_SPLINE_WINDOW_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define TCSW_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Clocked assertion on the block clock and reset.
`define TCSW_ASSERT(label, prop, msg) `TCSW_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

>>> src/tcsw_pkg.sv
package tcsw_pkg;

    // Fixed-point formats
    localparam int FRACTION_BITS = 16;
    localparam int DIL_FRAC      = 12;
    localparam int EXP_W         = 11;

    // Divider depths: 1/a needs 33 quotient bits, |r| needs 30 after its integer part
    localparam int DIV_STEPS = 33;
    localparam int T_STEPS   = 30;

    // Latency of one axis lane, from input beat to weights
    localparam int AX_LAT = 44;

    localparam int NUM_AXES = 3;
    localparam int NUM_OUT  = 10;
    localparam int IN_W     = 288;
    localparam int OUT_W    = 64 * NUM_OUT;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // floor(2^31 / 3) and the reciprocal of 6 scaled by 2^34 (exact for 31-bit values)
    localparam logic [31:0] TWO_THIRDS_Q30 = 32'd715827882;
    localparam logic [31:0] RECIP6         = 32'd2863311531;
    localparam int          RECIP6_SH      = 34;

    // Exponent of 1/a when A is normalized by lz leading zeros in 48 bits
    localparam int INV_EXP_BASE = 1 + DIL_FRAC + FRACTION_BITS - 32 - 47;

    typedef logic signed [EXP_W-1:0] exp_t;

    // Mantissa in [2^31, 2^32) or zero, value m * 2^e
    typedef struct packed {
        logic [31:0] m;
        exp_t        e;
    } uf_t;

    // Per-axis results handed from a lane to the product stages
    typedef struct packed {
        logic            cov;
        logic [3:0]      neg;
        uf_t  [3:0]      w;
    } axis_res_t;

    // Product of two mantissas, keep the top 32 bits
    function automatic uf_t uf_mul(uf_t a, uf_t b);
        logic [63:0] p;
        uf_t         r;
        p = {32'b0, a.m} * {32'b0, b.m};
        if (p[63]) begin
            r.m = p[63:32];
            r.e = a.e + b.e + exp_t'(32);
        end else begin
            r.m = p[62:31];
            r.e = a.e + b.e + exp_t'(31);
        end
        return r;
    endfunction

endpackage

>>> src/tcsw_axis.sv
module tcsw_axis (
    input  logic                  aclk,
    input  logic                  adv,
    input  logic signed [31:0]    node,
    input  logic signed [31:0]    point,
    input  logic [30:0]           support,
    input  logic [15:0]           dilation,
    output tcsw_pkg::axis_res_t   res
);

    typedef struct packed {
        logic        cov;
        logic        inner;
        logic        negd;
        logic [5:0]  lz;
        logic [46:0] a;
        logic [47:0] an;
        logic [31:0] t;
        logic [46:0] trem;
        logic [32:0] q;
        logic [47:0] qrem;
    } div_t;

    typedef struct packed {
        logic                     cov;
        logic                     inner;
        logic                     negd;
        logic [31:0]              t;
        logic [30:0]              v;
        logic [30:0]              v2;
        logic [30:0]              v3;
        logic [31:0]              f0in;
        logic [62:0]              prod6;
        logic [3:0][31:0]         fmag;
        logic [3:0]               fneg;
        tcsw_pkg::uf_t [3:0]      p;
    } post_t;

    typedef struct packed {
        logic                     cov;
        logic [3:0]               fneg;
        logic [3:0][31:0]         fmag;
        logic [3:0][4:0]          lz;
        tcsw_pkg::uf_t [3:0]      p;
        tcsw_pkg::uf_t [3:0]      fn;
    } norm_t;

    function automatic logic [5:0] lz_count48(logic [47:0] v);
        logic [5:0] lz;
        lz = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) lz = 6'(47 - i);
        end
        return lz;
    endfunction

    function automatic logic [4:0] lz_count32(logic [31:0] v);
        logic [4:0] lz;
        lz = 5'd31;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) lz = 5'(31 - i);
        end
        return lz;
    endfunction

    // Offset and support product
    logic signed [32:0] diff;
    logic [32:0]        absd_a1_reg;
    logic               negd_a1_reg;
    logic [46:0]        prod_a1_reg;

    assign diff = {point[31], point} - {node[31], node};

    always_ff @(posedge aclk) begin
        if (adv) begin
            negd_a1_reg <= diff[32];
            absd_a1_reg <= diff[32] ? 33'(-diff) : 33'(diff);
            prod_a1_reg <= 47'({31'b0, dilation} * {16'b0, support});
        end
    end

    // Coverage, piece select, integer part of |r|, normalize count of A
    logic [44:0] dd;
    logic [45:0] two_d;
    logic [47:0] two_a;
    logic [47:0] rem_wide;
    logic [1:0]  t0;
    logic        cov_a2_reg;
    logic        inner_a2_reg;
    logic        negd_a2_reg;
    logic [46:0] a_a2_reg;
    logic [1:0]  t0_a2_reg;
    logic [46:0] rem_a2_reg;
    logic [5:0]  lz_a2_reg;

    assign dd    = {absd_a1_reg, 12'b0};
    assign two_d = {absd_a1_reg, 13'b0};
    assign two_a = {prod_a1_reg, 1'b0};

    always_comb begin
        if ({2'b0, two_d} >= two_a) begin
            t0       = 2'd2;
            rem_wide = {2'b0, two_d} - two_a;
        end else if ({1'b0, two_d} >= prod_a1_reg) begin
            t0       = 2'd1;
            rem_wide = {2'b0, two_d} - {1'b0, prod_a1_reg};
        end else begin
            t0       = 2'd0;
            rem_wide = {2'b0, two_d};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cov_a2_reg   <= (prod_a1_reg != '0) && ({2'b0, dd} <= prod_a1_reg);
            inner_a2_reg <= negd_a1_reg ? ({1'b0, two_d} <= prod_a1_reg)
                                        : ({1'b0, two_d} <  prod_a1_reg);
            negd_a2_reg  <= negd_a1_reg;
            a_a2_reg     <= prod_a1_reg;
            t0_a2_reg    <= t0;
            rem_a2_reg   <= rem_wide[46:0];
            lz_a2_reg    <= lz_count48({1'b0, prod_a1_reg});
        end
    end

    // Normalize A, load both dividers
    div_t div_reg  [0:tcsw_pkg::DIV_STEPS];
    div_t div_next [0:tcsw_pkg::DIV_STEPS-1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            div_reg[0].cov   <= cov_a2_reg;
            div_reg[0].inner <= inner_a2_reg;
            div_reg[0].negd  <= negd_a2_reg;
            div_reg[0].lz    <= lz_a2_reg;
            div_reg[0].a     <= a_a2_reg;
            div_reg[0].an    <= {1'b0, a_a2_reg} << lz_a2_reg;
            div_reg[0].t     <= {30'b0, t0_a2_reg};
            div_reg[0].trem  <= rem_a2_reg;
            div_reg[0].q     <= '0;
            div_reg[0].qrem  <= 48'h8000_0000_0000;
        end
    end

    // One quotient bit per stage for 1/a, and for |r| in the first T_STEPS stages
    for (genvar j = 0; j < tcsw_pkg::DIV_STEPS; j++) begin : g_div
        always_comb begin
            logic [47:0] trs;
            logic        tge;
            logic [48:0] qrs;
            logic        qge;
            trs = {div_reg[j].trem, 1'b0};
            tge = trs >= {1'b0, div_reg[j].a};
            qrs = (j == 0) ? {1'b0, div_reg[j].qrem} : {div_reg[j].qrem, 1'b0};
            qge = qrs >= {1'b0, div_reg[j].an};
            div_next[j] = div_reg[j];
            if (j < tcsw_pkg::T_STEPS) begin
                div_next[j].t    = {div_reg[j].t[30:0], tge};
                div_next[j].trem = tge ? 47'(trs - {1'b0, div_reg[j].a}) : trs[46:0];
            end
            div_next[j].q    = (j == 0) ? {32'b0, qge} : {div_reg[j].q[31:0], qge};
            div_next[j].qrem = qge ? 48'(qrs - {1'b0, div_reg[j].an}) : qrs[47:0];
        end

        always_ff @(posedge aclk) begin
            if (adv) div_reg[j+1] <= div_next[j];
        end
    end

    // Polynomial terms and powers of 1/a
    post_t post_reg  [1:5];
    post_t post_next [1:5];

    always_comb begin
        logic [31:0] u;
        logic [32:0] t3x;
        div_t        dv;
        dv = div_reg[tcsw_pkg::DIV_STEPS];
        u   = 32'h8000_0000 - dv.t;
        t3x = {1'b0, dv.t} + {dv.t, 1'b0};
        post_next[1]       = '0;
        post_next[1].cov   = dv.cov;
        post_next[1].inner = dv.inner;
        post_next[1].negd  = dv.negd;
        post_next[1].t     = dv.t;
        post_next[1].v     = dv.inner ? dv.t[30:0] : u[30:0];
        if (!dv.inner) begin
            post_next[1].fmag[2] = u;
            post_next[1].fneg[2] = 1'b0;
        end else if (t3x >= 33'h0_8000_0000) begin
            post_next[1].fmag[2] = 32'(t3x - 33'h0_8000_0000);
            post_next[1].fneg[2] = 1'b0;
        end else begin
            post_next[1].fmag[2] = 32'(33'h0_8000_0000 - t3x);
            post_next[1].fneg[2] = 1'b1;
        end
        post_next[1].p[0].m = dv.q[32] ? 32'h8000_0000 : dv.q[31:0];
        post_next[1].p[0].e = tcsw_pkg::exp_t'(tcsw_pkg::INV_EXP_BASE)
                            + tcsw_pkg::exp_t'({1'b0, dv.lz})
                            + tcsw_pkg::exp_t'({1'b0, dv.q[32]});
    end

    // Square of the piece variable, (1/a)^2
    always_comb begin
        logic [61:0] sq;
        sq = {31'b0, post_reg[1].v} * {31'b0, post_reg[1].v};
        post_next[2]      = post_reg[1];
        post_next[2].v2   = sq[60:30];
        post_next[2].p[1] = tcsw_pkg::uf_mul(post_reg[1].p[0], post_reg[1].p[0]);
    end

    // Cube, first-derivative term, (1/a)^3
    always_comb begin
        logic [61:0] cb;
        logic [32:0] three_v2;
        logic [32:0] f1;
        cb       = {31'b0, post_reg[2].v2} * {31'b0, post_reg[2].v};
        three_v2 = {2'b0, post_reg[2].v2} + {1'b0, post_reg[2].v2, 1'b0};
        f1       = {post_reg[2].t, 1'b0} - {1'b0, three_v2[32:1]};
        post_next[3]         = post_reg[2];
        post_next[3].v3      = cb[60:30];
        post_next[3].p[2]    = tcsw_pkg::uf_mul(post_reg[2].p[1], post_reg[2].p[0]);
        post_next[3].fmag[1] = post_reg[2].inner ? f1[31:0] : {2'b0, post_reg[2].v2[30:1]};
        post_next[3].fneg[1] = post_reg[2].negd;
    end

    // Inner value term, outer cube over six, (1/a)^4
    always_comb begin
        logic [32:0] f0;
        f0 = {1'b0, tcsw_pkg::TWO_THIRDS_Q30} - {2'b0, post_reg[3].v2}
           + {3'b0, post_reg[3].v3[30:1]};
        post_next[4]       = post_reg[3];
        post_next[4].f0in  = f0[31:0];
        post_next[4].prod6 = 63'({32'b0, post_reg[3].v3} * {31'b0, tcsw_pkg::RECIP6});
        post_next[4].p[3]  = tcsw_pkg::uf_mul(post_reg[3].p[2], post_reg[3].p[0]);
    end

    // Settle value and third-derivative terms
    always_comb begin
        post_next[5]         = post_reg[4];
        post_next[5].fmag[0] = post_reg[4].inner ? post_reg[4].f0in
                                 : {3'b0, post_reg[4].prod6[62:tcsw_pkg::RECIP6_SH]};
        post_next[5].fneg[0] = 1'b0;
        post_next[5].fmag[3] = post_reg[4].inner ? 32'hC000_0000 : 32'h4000_0000;
        post_next[5].fneg[3] = post_reg[4].inner ? !post_reg[4].negd : post_reg[4].negd;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            post_reg[1] <= post_next[1];
            post_reg[2] <= post_next[2];
            post_reg[3] <= post_next[3];
            post_reg[4] <= post_next[4];
            post_reg[5] <= post_next[5];
        end
    end

    // Count leading zeros, then shift the terms into mantissa form
    norm_t norm_reg [0:1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            norm_reg[0].cov  <= post_reg[5].cov;
            norm_reg[0].fneg <= post_reg[5].fneg;
            norm_reg[0].fmag <= post_reg[5].fmag;
            norm_reg[0].p    <= post_reg[5].p;
            norm_reg[0].fn   <= '0;
            for (int k = 0; k < 4; k++) begin
                norm_reg[0].lz[k] <= lz_count32(post_reg[5].fmag[k]);
            end
            norm_reg[1] <= norm_reg[0];
            for (int k = 0; k < 4; k++) begin
                norm_reg[1].fn[k].m <= norm_reg[0].fmag[k] << norm_reg[0].lz[k];
                norm_reg[1].fn[k].e <= tcsw_pkg::exp_t'(-30)
                                     - tcsw_pkg::exp_t'({1'b0, norm_reg[0].lz[k]});
            end
        end
    end

    // Scale each term by its power of 1/a
    always_ff @(posedge aclk) begin
        if (adv) begin
            res.cov <= norm_reg[1].cov;
            res.neg <= norm_reg[1].fneg;
            for (int k = 0; k < 4; k++) begin
                res.w[k] <= tcsw_pkg::uf_mul(norm_reg[1].fn[k], norm_reg[1].p[k]);
            end
        end
    end

endmodule

>>> src/tensor_cubic_spline_window.sv
// Channel    Dir  Handshake          Payload
// s_         in   s_tvalid/s_tready  s_tdata: node, support and point per axis
// m_         out  m_tvalid/m_tready  m_tdata: weight and derivatives; m_tuser: covered
// cfg_       in   cfg_wr_en          cfg_index, cfg_wdata: dilation, order, mode
//
// One beat per cycle in and out while no finished beat is held on m_tready.
// Each axis lane runs restoring dividers for |r| and 1/a, the latter in 33 steps.
// Reset (aresetn, synchronous) clears all valid bits and loads the register defaults.
// A stall on m_tready freezes the whole pipeline in place; s_tready follows it.
module tensor_cubic_spline_window (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // node_x, node_y, node_z, support_x, support_y, support_z, point_x, point_y,
    // point_z, zero pad
    input  logic [tcsw_pkg::IN_W-1:0]           s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // weight, grad_x, grad_y, grad_z, curv_x, curv_y, curv_z, third_x, third_y, third_z
    output logic [tcsw_pkg::OUT_W-1:0]          m_tdata,
    // covered
    output logic                                m_tuser,
    input  logic                                cfg_wr_en,
    input  logic [tcsw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcsw_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    typedef enum logic [tcsw_pkg::CFG_IDX_W-1:0] {
        CFG_DIL_X       = 3'd0,
        CFG_DIL_Y       = 3'd1,
        CFG_DIL_Z       = 3'd2,
        CFG_DERIV_ORDER = 3'd3,
        CFG_THREE_DIMS  = 3'd4
    } cfg_reg_t;

    localparam int VLD_LEN = tcsw_pkg::AX_LAT + 3;

    logic [15:0] dil_x_reg;
    logic [15:0] dil_y_reg;
    logic [15:0] dil_z_reg;
    logic [1:0]  deriv_order_reg;
    logic        three_dims_reg;
    logic        adv;
    logic        m_valid_reg;
    logic        m_cov_reg;
    logic [tcsw_pkg::OUT_W-1:0] m_data_reg;
    logic [VLD_LEN-1:0] vld_reg;
    logic [15:0] dil [tcsw_pkg::NUM_AXES];
    tcsw_pkg::axis_res_t ax_res [tcsw_pkg::NUM_AXES];

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dil_x_reg       <= 16'd4096;
            dil_y_reg       <= 16'd4096;
            dil_z_reg       <= 16'd4096;
            deriv_order_reg <= 2'd0;
            three_dims_reg  <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                CFG_DIL_X:       dil_x_reg       <= cfg_wdata;
                CFG_DIL_Y:       dil_y_reg       <= cfg_wdata;
                CFG_DIL_Z:       dil_z_reg       <= cfg_wdata;
                CFG_DERIV_ORDER: deriv_order_reg <= cfg_wdata[1:0];
                CFG_THREE_DIMS:  three_dims_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Advance everything unless a finished beat is held
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[VLD_LEN-2:0], s_tvalid};
            m_valid_reg <= vld_reg[VLD_LEN-1];
        end
    end

    assign dil[0] = dil_x_reg;
    assign dil[1] = dil_y_reg;
    assign dil[2] = dil_z_reg;

    // Axis lanes
    for (genvar i = 0; i < tcsw_pkg::NUM_AXES; i++) begin : g_axis
        tcsw_axis u_axis (
            .aclk     (aclk),
            .adv      (adv),
            .node     (s_tdata[32*i +: 32]),
            .point    (s_tdata[189 + 32*i +: 32]),
            .support  (s_tdata[96 + 31*i +: 31]),
            .dilation (dil[i]),
            .res      (ax_res[i])
        );
    end

    // Cross-axis products and output conversion
    tcsw_pkg::uf_t [tcsw_pkg::NUM_AXES-1:0] t1_w0_reg;
    logic t1_cov_reg;
    logic t2_cov_reg;
    logic t3_cov_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            t1_cov_reg <= ax_res[0].cov && ax_res[1].cov && (ax_res[2].cov || !three_dims_reg);
            t2_cov_reg <= t1_cov_reg;
            t3_cov_reg <= t2_cov_reg;
            m_cov_reg  <= t3_cov_reg;
            for (int i = 0; i < tcsw_pkg::NUM_AXES; i++) begin
                t1_w0_reg[i] <= ax_res[i].w[0];
            end
        end
    end

    for (genvar o = 0; o < tcsw_pkg::NUM_OUT; o++) begin : g_out
        localparam int K  = (o == 0) ? 0 : (o - 1) / 3 + 1;
        localparam int I  = (o == 0) ? 0 : (o - 1) % 3;
        localparam int J1 = (I == 0) ? 1 : 0;
        localparam int J2 = (I == 2) ? 1 : 2;

        tcsw_pkg::uf_t t1_acc_reg;
        tcsw_pkg::uf_t t2_acc_reg;
        logic          t1_neg_reg;
        logic          t2_neg_reg;
        logic          t3_neg_reg;
        logic          t3_sat_reg;
        logic [63:0]   t3_mag_reg;
        logic [63:0]   mag_next;
        logic          sat_next;
        logic [63:0]   val_next;
        logic          keep;

        // Convert the mantissa to Q32.32 magnitude with saturation flag
        always_comb begin
            tcsw_pkg::exp_t sh;
            tcsw_pkg::exp_t nsh;
            sh  = t2_acc_reg.e + tcsw_pkg::exp_t'(32);
            nsh = -sh;
            mag_next = '0;
            sat_next = 1'b0;
            if (t2_acc_reg.m == '0) begin
                mag_next = '0;
            end else if (sh >= tcsw_pkg::exp_t'(32)) begin
                sat_next = 1'b1;
            end else if (sh >= tcsw_pkg::exp_t'(0)) begin
                mag_next = {32'b0, t2_acc_reg.m} << sh[4:0];
            end else if (sh > tcsw_pkg::exp_t'(-64)) begin
                mag_next = {32'b0, t2_acc_reg.m} >> nsh[5:0];
            end
        end

        // Apply sign, limits and zero gating
        assign keep = t3_cov_reg && (2'(K) <= deriv_order_reg) && ((I != 2) || three_dims_reg);

        always_comb begin
            if (!keep) begin
                val_next = '0;
            end else if (t3_neg_reg) begin
                val_next = t3_sat_reg ? 64'h8000_0000_0000_0000 : (~t3_mag_reg + 64'd1);
            end else begin
                val_next = t3_sat_reg ? 64'h7FFF_FFFF_FFFF_FFFF : t3_mag_reg;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                t1_acc_reg <= tcsw_pkg::uf_mul(ax_res[I].w[K], ax_res[J1].w[0]);
                t1_neg_reg <= ax_res[I].neg[K];
                t2_acc_reg <= three_dims_reg ? tcsw_pkg::uf_mul(t1_acc_reg, t1_w0_reg[J2])
                                             : t1_acc_reg;
                t2_neg_reg <= t1_neg_reg;
                t3_mag_reg <= mag_next;
                t3_sat_reg <= sat_next;
                t3_neg_reg <= t2_neg_reg;
                m_data_reg[64*o +: 64] <= val_next;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_cov_reg;

endmodule

>>> src/tcsw_checker.sv
`include "tensor_cubic_spline_window_macros.svh"

module tcsw_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [tcsw_pkg::OUT_W-1:0]  m_tdata,
    input logic                        m_tuser
);

    // A held beat stays put
    `TCSW_ASSERT(a_hold_beat, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "held beat changed")

    // An empty output stage never blocks the input
    `TCSW_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready, "input blocked with empty output")

    // Uncovered points give all-zero results
    `TCSW_ASSERT(a_zero_uncovered, m_tvalid && !m_tuser |-> m_tdata == '0, "uncovered beat not zero")

    // The window value is never negative
    `TCSW_ASSERT(a_weight_sign, m_tvalid |-> !m_tdata[63], "negative weight")

endmodule

bind tensor_cubic_spline_window tcsw_checker u_tcsw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> test/tcsw_tb_pkg.sv
package tcsw_tb_pkg;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_DIL_X   = 3'd0,
        REG_DIL_Y   = 3'd1,
        REG_DIL_Z   = 3'd2,
        REG_ORDER   = 3'd3,
        REG_THREE_D = 3'd4
    } cfg_reg_e;

    // Dilation register default after reset
    localparam logic [15:0] DIL_DEFAULT = 16'd4096;

endpackage

>>> test/tcsw_window_checker.sv
module tcsw_window_checker
    import tcsw_tb_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [287:0]  s_tdata,
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [639:0]  m_tdata,
    input  logic          m_tuser,
    input  logic          cfg_wr_en,
    input  logic [2:0]    cfg_index,
    input  logic [15:0]   cfg_wdata,
    output int            fail_count,
    output int            pending
);

    // Mantissa in [2^31, 2^32) or zero, value m * 2^e
    typedef struct {
        logic [31:0] m;
        int          e;
    } fnum_t;

    typedef struct packed {
        logic              cov;
        logic [9:0][63:0]  val;
    } window_t;

    window_t     window_q[$];
    logic [15:0] dil [3];
    logic [1:0]  order;
    logic        three_d;
    string       field_name [10] = '{"weight", "grad_x", "grad_y", "grad_z", "curv_x",
                                     "curv_y", "curv_z", "third_x", "third_y", "third_z"};

    function automatic fnum_t fnorm(logic [63:0] v, int e);
        fnum_t r;
        r.m = 0;
        r.e = 0;
        if (v == 0) return r;
        while ((v >> 32) != 0) begin
            v = v >> 1;
            e++;
        end
        while (v[31] == 1'b0) begin
            v = v << 1;
            e--;
        end
        r.m = v[31:0];
        r.e = e;
        return r;
    endfunction

    // Keep the top 32 bits of the mantissa product
    function automatic fnum_t fmul(fnum_t a, fnum_t b);
        fnum_t       r;
        logic [63:0] p;
        r.m = 0;
        r.e = 0;
        if (a.m == 0 || b.m == 0) return r;
        p = {32'b0, a.m} * {32'b0, b.m};
        if (p[63]) begin
            r.m = p[63:32];
            r.e = a.e + b.e + 32;
        end else begin
            r.m = p[62:31];
            r.e = a.e + b.e + 31;
        end
        return r;
    endfunction

    // Truncate to Q32.32, apply sign, saturate
    function automatic logic [63:0] to_q32(fnum_t v, bit neg);
        logic [63:0] top;
        logic [63:0] mag;
        int          sh;
        top = 64'h8000_0000_0000_0000;
        sh = v.e + 32;
        if (v.m == 0) return 64'd0;
        if (sh >= 32) mag = top;
        else if (sh >= 0) mag = {32'b0, v.m} << sh;
        else if (sh > -64) mag = {32'b0, v.m} >> (-sh);
        else mag = 0;
        if (neg) return (mag >= top) ? top : (~mag + 64'd1);
        return (mag >= top) ? (top - 64'd1) : mag;
    endfunction

    // One axis: coverage, spline factors and weights
    function automatic bit eval_axis(input logic signed [31:0] node, input logic signed [31:0] pnt,
                                     input logic [15:0] dl, input logic [30:0] sup,
                                     output longint f [4], output fnum_t w [4]);
        logic [63:0] big_a, dd, t, rem, q, t2, t3, u, u2, u3, mag;
        longint      d, sg, p1, p2, p3;
        bit          ng, inner;
        int          n;
        fnum_t       inv, pw;
        for (int k = 0; k < 4; k++) begin
            f[k] = 0;
            w[k] = fnorm(64'd0, 0);
        end
        big_a = {48'b0, dl} * {33'b0, sup};
        d = longint'(pnt) - longint'(node);
        ng = d < 0;
        dd = (ng ? 64'(-d) : 64'(d)) << 12;
        if (big_a == 0 || dd > big_a) return 1'b0;
        t = (2 * dd) / big_a;
        rem = 2 * dd - t * big_a;
        for (int i = 0; i < 30; i++) begin
            rem = rem << 1;
            t = t << 1;
            if (rem >= big_a) begin
                rem = rem - big_a;
                t = t | 64'd1;
            end
        end
        inner = ng ? (2 * dd <= big_a) : (2 * dd < big_a);
        sg = ng ? -1 : 1;
        if (inner) begin
            t2 = (t * t) >> 30;
            t3 = (t2 * t) >> 30;
            f[0] = longint'(715827882) - longint'(t2) + longint'(t3 >> 1);
            p1 = longint'(2 * t) - longint'((3 * t2) >> 1);
            p2 = longint'(3 * t) - (longint'(2) << 30);
            p3 = 3;
        end else begin
            u = (64'd2 << 30) - t;
            u2 = (u * u) >> 30;
            u3 = (u2 * u) >> 30;
            f[0] = longint'(u3 / 6);
            p1 = longint'(u2 >> 1);
            p2 = longint'(u);
            p3 = -1;
        end
        f[1] = sg * p1;
        f[2] = p2;
        f[3] = -sg * p3 * (longint'(1) << 30);
        // reciprocal of A by long division
        n = 0;
        while (n < 62 && (big_a >> (n + 1)) != 0) n++;
        q = 0;
        rem = 1;
        if (rem >= big_a) begin
            rem = rem - big_a;
            q = 1;
        end
        for (int i = 0; i < n + 32; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= big_a) begin
                rem = rem - big_a;
                q = q | 64'd1;
            end
        end
        inv = fnorm(q, 1 + 12 + 16 - (n + 32));
        pw = inv;
        for (int k = 0; k < 4; k++) begin
            mag = (f[k] < 0) ? 64'(-f[k]) : 64'(f[k]);
            if (k > 0) pw = fmul(pw, inv);
            w[k] = fmul(fnorm(mag, -30), pw);
        end
        return 1'b1;
    endfunction

    function automatic window_t predict_window(logic [287:0] beat);
        window_t r;
        longint  f [3][4];
        fnum_t   w [3][4];
        fnum_t   acc;
        bit      cov, neg;
        int      nd;
        r = '0;
        cov = 1'b1;
        nd = three_d ? 3 : 2;
        for (int i = 0; i < nd; i++) begin
            if (!eval_axis(beat[32*i +: 32], beat[189 + 32*i +: 32], dil[i],
                           beat[96 + 31*i +: 31], f[i], w[i]))
                cov = 1'b0;
        end
        if (!cov) return r;
        r.cov = 1'b1;
        for (int k = 0; k <= int'(order); k++) begin
            for (int i = 0; i < nd; i++) begin
                acc = w[i][k];
                neg = f[i][k] < 0;
                for (int j = 0; j < nd; j++) begin
                    if (j != i) begin
                        acc = fmul(acc, w[j][0]);
                        neg = neg != (f[j][0] < 0);
                    end
                end
                if (k == 0) begin
                    r.val[0] = to_q32(acc, neg);
                    break;
                end
                r.val[1 + 3 * (k - 1) + i] = to_q32(acc, neg);
            end
        end
        return r;
    endfunction

    assign pending = window_q.size();

    always @(posedge aclk) begin
        window_t exp_w;
        int      bad;
        if (!aresetn) begin
            dil[0] <= DIL_DEFAULT;
            dil[1] <= DIL_DEFAULT;
            dil[2] <= DIL_DEFAULT;
            order <= 2'd0;
            three_d <= 1'b1;
        end else begin
            // predict each accepted input beat
            if (s_tvalid && s_tready)
                window_q.push_back(predict_window(s_tdata));
            // compare each accepted result beat
            if (m_tvalid && m_tready) begin
                if (window_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result beat: tuser %b", m_tuser);
                    fail_count++;
                end else begin
                    exp_w = window_q.pop_front();
                    bad = 0;
                    if (m_tuser !== exp_w.cov) begin
                        bad = 1;
                        if (fail_count < 10)
                            $display("mismatch covered: expected %b got %b", exp_w.cov, m_tuser);
                    end
                    for (int i = 0; i < 10; i++) begin
                        if (m_tdata[64*i +: 64] !== exp_w.val[i]) begin
                            bad = 1;
                            if (fail_count < 10)
                                $display("mismatch %s: expected %h got %h", field_name[i],
                                         exp_w.val[i], m_tdata[64*i +: 64]);
                        end
                    end
                    if (bad != 0) fail_count++;
                end
            end
            // track register writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_DIL_X:   dil[0] <= cfg_wdata;
                    REG_DIL_Y:   dil[1] <= cfg_wdata;
                    REG_DIL_Z:   dil[2] <= cfg_wdata;
                    REG_ORDER:   order <= cfg_wdata[1:0];
                    REG_THREE_D: three_d <= cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    initial fail_count = 0;

endmodule

>>> test/tb_tensor_cubic_spline_window.sv
module tb_tensor_cubic_spline_window;
    import tcsw_tb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN       = 80;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [287:0]  s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [639:0]  m_tdata;
    logic          m_tuser;
    logic          cfg_wr_en = 1'b0;
    logic [2:0]    cfg_index = '0;
    logic [15:0]   cfg_wdata = '0;
    int            fail_count;
    int            pending;
    int            cycles = 0;
    bit            tx_idle_en = 1'b1;
    bit            rx_idle_en = 1'b1;
    bit            hold_req = 1'b0;
    logic [15:0]   cur_dil [3] = '{16'd4096, 16'd4096, 16'd4096};

    tensor_cubic_spline_window dut (.*);

    tcsw_window_checker checker_i (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Abort on a hung run
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** tensor_cubic_spline_window: FAILED **");
            $finish;
        end
    end

    // Result side: random idling plus one long hold-off on request
    initial begin
        int hold_cnt;
        hold_cnt = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = 300;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(rx_idle_en && $urandom_range(0, 99) < 10);
            end
        end
    end

    function automatic logic [287:0] pack_beat(logic [31:0] nd [3], logic [30:0] sp [3],
                                               logic [31:0] pt [3]);
        return {3'b0, pt[2], pt[1], pt[0], sp[2], sp[1], sp[0], nd[2], nd[1], nd[0]};
    endfunction

    task automatic send_beat(logic [287:0] beat);
        if (tx_idle_en && $urandom_range(0, 99) < 10) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tdata <= beat;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_e idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic set_config(logic [15:0] dx, logic [15:0] dy, logic [15:0] dz,
                              logic [1:0] ord, logic td);
        wait_drained();
        write_reg(REG_DIL_X, dx);
        write_reg(REG_DIL_Y, dy);
        write_reg(REG_DIL_Z, dz);
        write_reg(REG_ORDER, {14'b0, ord});
        write_reg(REG_THREE_D, {15'b0, td});
        cfg_wr_en <= 1'b0;
        cur_dil[0] = dx;
        cur_dil[1] = dy;
        cur_dil[2] = dz;
    endtask

    // Same node on every axis, point offset per axis
    task automatic send_offsets(logic [31:0] node, longint d0, longint d1, longint d2,
                                logic [30:0] sup);
        logic [31:0] nd [3];
        logic [30:0] sp [3];
        logic [31:0] pt [3];
        nd = '{node, node, node};
        sp = '{sup, sup, sup};
        pt[0] = 32'(longint'($signed(node)) + d0);
        pt[1] = 32'(longint'($signed(node)) + d1);
        pt[2] = 32'(longint'($signed(node)) + d2);
        send_beat(pack_beat(nd, sp, pt));
    endtask

    // Mostly points inside the support, some raw noise and near misses
    task automatic send_random();
        logic [31:0] nd [3];
        logic [30:0] sp [3];
        logic [31:0] pt [3];
        longint      lim, off;
        int          kind, wd;
        kind = $urandom_range(0, 99);
        for (int i = 0; i < 3; i++) begin
            nd[i] = $urandom;
            if (kind < 15) begin
                sp[i] = 31'($urandom);
                pt[i] = $urandom;
            end else begin
                wd = $urandom_range(1, 31);
                sp[i] = 31'($urandom) & 31'((64'd1 << wd) - 1);
                if (sp[i] == 0) sp[i] = 31'd1;
                lim = (longint'(cur_dil[i]) * longint'(sp[i])) >>> 12;
                off = longint'({$urandom, $urandom} % 64'(2 * lim + 1)) - lim;
                if ($urandom_range(0, 99) < 4) off = ($urandom_range(0, 1) != 0) ? lim + 1 : -lim - 1;
                pt[i] = 32'(longint'($signed(nd[i])) + off);
            end
        end
        send_beat(pack_beat(nd, sp, pt));
    endtask

    initial begin
        int nrand;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults after reset
        repeat (5) send_random();

        // directed: center, edges, inner/outer boundary, extremes
        set_config(16'd4096, 16'd4096, 16'd4096, 2'd3, 1'b1);
        send_offsets(32'h0001_0000, 0, 0, 0, 31'd65536);
        send_offsets(32'h0001_0000, 65536, -65536, 0, 31'd65536);
        send_offsets(32'h0001_0000, 32768, -32768, 32767, 31'd65536);
        send_offsets(32'h0001_0000, -32767, 32769, -32769, 31'd65536);
        send_offsets(32'h0001_0000, 65537, 0, 0, 31'd65536);
        send_offsets(32'h0001_0000, 0, 0, -65537, 31'd65536);
        send_offsets(32'h0, 0, 0, 0, 31'd1);
        send_offsets(32'h0, 1, -1, 0, 31'd2);
        send_offsets(32'h7FFF_FFFF, 0, 0, 0, 31'h7FFF_FFFF);
        send_offsets(32'h8000_0000, 0, 0, 0, 31'h7FFF_FFFF);
        send_offsets(32'h8000_0000, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 0, 31'h7FFF_FFFF);
        send_offsets(32'hC000_0000, 64'h3FFF_FFFF, -64'h3FFF_FFFF, 12345, 31'h7FFF_FFFF);
        send_offsets(32'h0, -100, 100, 5, 31'd300);
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3, 1'b0);
        send_offsets(32'h8000_0000, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 0, 31'h7FFF_FFFF);
        send_offsets(32'h0, 0, 0, 64'h7FFF_FFFF, 31'd1);
        send_offsets(32'h0, 15, -15, 0, 31'd1);
        set_config(16'd1, 16'd1, 16'd1, 2'd3, 1'b1);
        send_offsets(32'h0, 0, 0, 0, 31'd1);
        send_offsets(32'h0, 1, 0, 0, 31'h7FFF_FFFF);
        send_offsets(32'h1234_5678, 0, 0, 0, 31'd8192);

        // random phases over several settings
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: set_config(16'd4096, 16'd4096, 16'd4096, 2'd3, 1'b1);
                1: set_config(16'd1, 16'd1, 16'd1, 2'd1, 1'b1);
                2: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd2, 1'b0);
                3: set_config(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                              16'($urandom_range(1, 65535)), 2'd0, 1'b1);
                default: set_config(16'($urandom_range(1, 65535)),
                                    16'($urandom_range(1, 65535)),
                                    16'($urandom_range(1, 65535)),
                                    2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            endcase
            // no idling on either side in one phase
            tx_idle_en = (ph != 1);
            rx_idle_en = (ph != 1);
            nrand = 105;
            for (int i = 0; i < nrand; i++) begin
                if (ph == 0 && i == 10) hold_req = 1'b1;
                if (ph == 4 && i == 50) wait_drained();
                send_random();
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("** tensor_cubic_spline_window: PASSED **");
        else
            $display("** tensor_cubic_spline_window: FAILED **");
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/tcsw_pkg.sv
src/tcsw_axis.sv
src/tensor_cubic_spline_window.sv
src/tcsw_checker.sv
test/tcsw_tb_pkg.sv
test/tcsw_window_checker.sv
test/tb_tensor_cubic_spline_window.sv
